// ===== hw/rtl/lpkst_pkg.sv =====
package lpkst_pkg;

   // Field widths
   localparam int KEY_W      = 64;
   localparam int RSP_SLOT_W = 8;

   // Hash: eight 8-bit bytes times weights of at most 5 bits, XOR-ed, fit in 13 bits
   localparam int HASH_W   = 13;
   localparam int HASH_MAX = (1 << HASH_W) - 1;

   localparam int DEF_TABLE_SLOTS = 256;

   localparam logic [4:0] BYTE_WEIGHT [0:7] = '{5'd1, 5'd3, 5'd5, 5'd7,
                                                5'd31, 5'd13, 5'd17, 5'd23};

   // Result kinds loaded into the response register
   typedef enum logic [1:0] {
      RSP_REJECT = 2'd0,
      RSP_INSERT = 2'd1,
      RSP_FOUND  = 2'd2,
      RSP_FULL   = 2'd3
   } lpkst_rsp_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic              clear_en;
      logic              capture;
      logic              reduce_hi;
      logic              probe_start;
      logic              probe_advance;
      logic              insert_wr;
      logic              rsp_load;
      lpkst_rsp_sel_type rsp_sel;
   } lpkst_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic key_bad;
      logic probe_empty;
      logic probe_match;
      logic probe_last;
      logic rsp_free;
   } lpkst_sts_type;

   // Weighted byte XOR hash of a key, byte 0 in bits 7:0
   function automatic logic [HASH_W-1:0] lpkst_hash(input logic [KEY_W-1:0] key);
      logic [HASH_W-1:0] acc;
      acc = '0;
      for (int b = 0; b < 8; b++) begin
         acc = acc ^ (HASH_W'(key[8*b +: 8]) * HASH_W'(BYTE_WEIGHT[b]));
      end
      return acc;
   endfunction

endpackage

// ===== hw/rtl/lpkst_ctrl.sv =====
module lpkst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lpkst_pkg::lpkst_sts_type sts,
   output lpkst_pkg::lpkst_cmd_type cmd
);
   import lpkst_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_HASH_HI = 5'b00100,
      ST_HASH_LO = 5'b01000,
      ST_PROBE   = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Accept a request only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // Sequence clearing, hashing and probing
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_HASH_HI;
            end
         end
         ST_HASH_HI: begin
            if (sts.key_bad) begin
               if (sts.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = RSP_REJECT;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.reduce_hi = 1'b1;
               state_in      = ST_HASH_LO;
            end
         end
         ST_HASH_LO: begin
            cmd.probe_start = 1'b1;
            state_in        = ST_PROBE;
         end
         ST_PROBE: begin
            // Decide on the slot just read; hold it while the response is blocked
            priority if (sts.probe_empty) begin
               if (sts.rsp_free) begin
                  cmd.insert_wr = 1'b1;
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_sel   = RSP_INSERT;
                  state_in      = ST_IDLE;
               end
            end else if (sts.probe_match) begin
               if (sts.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = RSP_FOUND;
                  state_in     = ST_IDLE;
               end
            end else if (sts.probe_last) begin
               if (sts.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = RSP_FULL;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.probe_advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/lpkst_datapath.sv =====
module lpkst_datapath #(
   parameter int TABLE_SLOTS = lpkst_pkg::DEF_TABLE_SLOTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lpkst_pkg::KEY_W-1:0]        req_lookup_key,
   input  logic                               csr_wr_en,
   input  logic [lpkst_pkg::KEY_W-1:0]        csr_wr_data,
   input  logic                               rsp_stall,
   input  lpkst_pkg::lpkst_cmd_type           cmd,
   output lpkst_pkg::lpkst_sts_type           sts,
   output logic                               rsp_valid,
   output logic [lpkst_pkg::RSP_SLOT_W-1:0]   rsp_slot_index,
   output logic                               rsp_already_present,
   output logic                               rsp_key_accepted,
   output logic                               rsp_table_full
);
   import lpkst_pkg::*;

   localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SLOT_LAST  = TABLE_SLOTS - 1;
   localparam int HASH_SPLIT = 6;

   // Configuration and captured request
   logic [KEY_W-1:0]      invalid_key_ff;
   logic [KEY_W-1:0]      key_ff;
   logic                  key_bad_ff;
   logic [HASH_W-1:0]     hash_ff;
   logic [HASH_W-1:0]     hash_hi;
   logic [HASH_W-1:0]     hash_lo;
   logic [SLOT_W-1:0]     slot_home;

   // Probe walk
   logic [SLOT_W-1:0]     clear_ff;
   logic [SLOT_W-1:0]     rd_addr;
   logic [SLOT_W-1:0]     cmp_slot_ff;
   logic [SLOT_W-1:0]     next_slot_ff;
   logic [SLOT_W-1:0]     probe_cnt_ff;
   logic [KEY_W-1:0]      rd_key_ff;
   logic                  rd_occ_ff;

   // Table storage
   logic [KEY_W-1:0]      key_mem [TABLE_SLOTS];
   logic                  occ_mem [TABLE_SLOTS];

   // Response register
   logic                  rsp_valid_ff;
   logic [RSP_SLOT_W-1:0] rsp_slot_ff;
   logic                  rsp_present_ff;
   logic                  rsp_accepted_ff;
   logic                  rsp_full_ff;

   function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      n = (s == SLOT_W'(SLOT_LAST)) ? '0 : s + 1'b1;
      return n;
   endfunction

   // Reduce the hash modulo the table size: upper subtract steps
   always_comb begin
      hash_hi = hash_ff;
      for (int k = HASH_W - 1; k >= HASH_SPLIT; k--) begin
         if ((TABLE_SLOTS << k) <= HASH_MAX) begin
            if (hash_hi >= HASH_W'(TABLE_SLOTS << k)) begin
               hash_hi = hash_hi - HASH_W'(TABLE_SLOTS << k);
            end
         end
      end
   end

   // Lower subtract steps give the home slot
   always_comb begin
      hash_lo = hash_ff;
      for (int k = HASH_SPLIT - 1; k >= 0; k--) begin
         if ((TABLE_SLOTS << k) <= HASH_MAX) begin
            if (hash_lo >= HASH_W'(TABLE_SLOTS << k)) begin
               hash_lo = hash_lo - HASH_W'(TABLE_SLOTS << k);
            end
         end
      end
      slot_home = SLOT_W'(hash_lo);
   end

   // Hold the invalid key register
   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_key_ff <= '0;
      end else if (csr_wr_en) begin
         invalid_key_ff <= csr_wr_data;
      end
   end

   // Capture the request and hash it
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff     <= req_lookup_key;
         key_bad_ff <= (req_lookup_key == invalid_key_ff);
         hash_ff    <= lpkst_hash(req_lookup_key);
      end else if (cmd.reduce_hi) begin
         hash_ff <= hash_hi;
      end
   end

   // Sweep the occupancy marks after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
      end else if (cmd.clear_en) begin
         clear_ff <= slot_wrap(clear_ff);
      end
   end

   // Pick the slot to read: home, next in line, or re-read the current one
   always_comb begin
      priority if (cmd.probe_start) begin
         rd_addr = slot_home;
      end else if (cmd.probe_advance) begin
         rd_addr = next_slot_ff;
      end else begin
         rd_addr = cmp_slot_ff;
      end
   end

   // Advance the probe pointer and count
   always_ff @(posedge clock) begin
      cmp_slot_ff <= rd_addr;
      if (cmd.probe_start) begin
         next_slot_ff <= slot_wrap(slot_home);
         probe_cnt_ff <= '0;
      end else if (cmd.probe_advance) begin
         next_slot_ff <= slot_wrap(next_slot_ff);
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end
   end

   // Table memories, registered read
   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_occ_ff <= occ_mem[rd_addr];
      if (cmd.insert_wr) begin
         key_mem[cmp_slot_ff] <= key_ff;
      end
      if (cmd.clear_en) begin
         occ_mem[clear_ff] <= 1'b0;
      end else if (cmd.insert_wr) begin
         occ_mem[cmp_slot_ff] <= 1'b1;
      end
   end

   // Load the response register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_sel)
            RSP_REJECT: begin
               rsp_slot_ff     <= '0;
               rsp_present_ff  <= 1'b0;
               rsp_accepted_ff <= 1'b0;
               rsp_full_ff     <= 1'b0;
            end
            RSP_INSERT: begin
               rsp_slot_ff     <= RSP_SLOT_W'(cmp_slot_ff);
               rsp_present_ff  <= 1'b0;
               rsp_accepted_ff <= 1'b1;
               rsp_full_ff     <= 1'b0;
            end
            RSP_FOUND: begin
               rsp_slot_ff     <= RSP_SLOT_W'(cmp_slot_ff);
               rsp_present_ff  <= 1'b1;
               rsp_accepted_ff <= 1'b1;
               rsp_full_ff     <= 1'b0;
            end
            RSP_FULL: begin
               rsp_slot_ff     <= '0;
               rsp_present_ff  <= 1'b0;
               rsp_accepted_ff <= 1'b1;
               rsp_full_ff     <= 1'b1;
            end
            default: begin
               rsp_slot_ff     <= '0;
               rsp_present_ff  <= 1'b0;
               rsp_accepted_ff <= 1'b0;
               rsp_full_ff     <= 1'b0;
            end
         endcase
      end
   end

   // Status back to the controller
   always_comb begin
      sts.clear_last  = (clear_ff == SLOT_W'(SLOT_LAST));
      sts.key_bad     = key_bad_ff;
      sts.probe_empty = !rd_occ_ff;
      sts.probe_match = (rd_key_ff == key_ff);
      sts.probe_last  = (probe_cnt_ff == SLOT_W'(SLOT_LAST));
      sts.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_already_present = rsp_present_ff;
   assign rsp_key_accepted    = rsp_accepted_ff;
   assign rsp_table_full      = rsp_full_ff;

   // Insert only into a slot that read back as empty
   a_insert_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_wr |-> !rd_occ_ff)
      else $error("insert into an occupied slot");

   // A found result comes from an occupied slot holding the same key
   a_found_match: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && (cmd.rsp_sel == RSP_FOUND)) |-> (rd_occ_ff && (rd_key_ff == key_ff)))
      else $error("found result without a matching stored key");

   // Never overwrite a response that is still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   // No insert while the occupancy sweep runs
   a_no_insert_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> (!cmd.insert_wr && !cmd.capture))
      else $error("request activity during occupancy sweep");

endmodule

// ===== hw/rtl/linear_probe_key_slot_table_unit.sv =====
// Hash table of 64-bit keys with linear probing.
// Request channel: req_valid / req_stall with req_lookup_key. Response channel:
// rsp_valid / rsp_stall with slot index, already-present, key-accepted and full.
// A request moves at a rising edge with valid high and stall low.
// csr_wr_en / csr_wr_data write the invalid key; write it only while idle.
// A request is captured, its hash reduced, and the table probed from the home
// slot (one memory read per cycle, pipelined) until a response registers. A key
// equal to the invalid key is rejected without a probe. The next request is taken
// at the edge after its response registers.
// A full table costs TABLE_SLOTS probes and answers with table_full set.
// After reset the occupancy memory is swept, one slot a cycle, over all TABLE_SLOTS
// slots; req_stall stays high meanwhile. The invalid key resets to zero.
// A response waits in its register while rsp_stall is high; a following
// request is still taken and held at its result until the register frees.
module linear_probe_key_slot_table_unit #(
   parameter int TABLE_SLOTS = lpkst_pkg::DEF_TABLE_SLOTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lpkst_pkg::KEY_W-1:0]      req_lookup_key,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lpkst_pkg::RSP_SLOT_W-1:0] rsp_slot_index,
   output logic                             rsp_already_present,
   output logic                             rsp_key_accepted,
   output logic                             rsp_table_full,
   input  logic                             csr_wr_en,
   input  logic [lpkst_pkg::KEY_W-1:0]      csr_wr_data
);
   import lpkst_pkg::*;

   lpkst_cmd_type cmd;
   lpkst_sts_type sts;

   lpkst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpkst_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_lookup_key      (req_lookup_key),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_stall           (rsp_stall),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_valid),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_already_present (rsp_already_present),
      .rsp_key_accepted    (rsp_key_accepted),
      .rsp_table_full      (rsp_table_full)
   );

endmodule
